FILE: rtl/core/periodic_task_dispatch_table_assert.svh
// assertion macros shared by the checker
`ifndef PERIODIC_TASK_DISPATCH_TABLE_ASSERT_SVH
`define PERIODIC_TASK_DISPATCH_TABLE_ASSERT_SVH
// implication checked on every clock edge outside reset
`define PTD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define PTD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

FILE: rtl/core/ptd_pkg.sv
package ptd_pkg;
  localparam int unsigned TaskSlots = 32;
  localparam int unsigned SlotW = 5;
  localparam int unsigned CntW = 6;

  typedef enum logic [2:0] {
    OpCreate = 3'd0, OpKill = 3'd1, OpKillAll = 3'd2, OpSetPeriod = 3'd3, OpRun = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    StDone = 3'd0, StPresent = 3'd1, StFull = 3'd2, StNull = 3'd3, StAbsent = 3'd4,
    StDue = 3'd5
  } status_e;

  // one table entry
  typedef struct packed {
    logic [15:0] key;
    logic [31:0] period;
    logic [31:0] last_run;
  } entry_t;
  localparam int unsigned EntryW = 80;
endpackage

FILE: rtl/core/periodic_task_dispatch_table.sv
// channel | ports                                  | handshake
// command | func_i task_key_i period_i now_tick_i  | start_i while busy_o low
// result  | status_o slot_o due_key_o last_o        | valid_o, one cycle, no stall
// From the accepting edge busy_o stays high through the result marked with last_o:
// the entry memory is read one slot per cycle through a registered read port; kill
// reads and writes one slot per cycle while shifting down. Search, run and kill walk
// the live slots in order.
// Reset clears the state, live count, slot index and read-pending flag; the memory holds no reset value.
// The receiver cannot stall; each result shows for one cycle with valid_o.
module periodic_task_dispatch_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  func_i,
  input  logic [15:0] task_key_i,
  input  logic [31:0] period_i,
  input  logic [31:0] now_tick_i,
  output logic        valid_o,
  output logic [2:0]  status_o,
  output logic [4:0]  slot_o,
  output logic [15:0] due_key_o,
  output logic        last_o
);
  import ptd_pkg::*;

  typedef enum logic [3:0] {
    SIdle = 4'b0001, SScan = 4'b0010, SShift = 4'b0100, SEnd = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [CntW-1:0] live_q, live_d;
  logic [CntW-1:0] idx_q, idx_d;      // slot whose read was issued last cycle
  logic            rd_pend_q, rd_pend_d;
  logic [2:0]      func_q;
  logic [15:0]     key_q;
  logic [31:0]     period_q, now_q;
  logic [2:0]      fst_q, fst_d;
  logic [SlotW-1:0] fslot_q, fslot_d;

  logic             we;
  logic [SlotW-1:0] waddr, raddr;
  entry_t           wdata, rdata;
  logic [EntryW-1:0] rdata_raw;

  ptd_ram #(.Width(EntryW), .Depth(TaskSlots)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata), .raddr_i(raddr),
    .rdata_o(rdata_raw)
  );
  assign rdata = entry_t'(rdata_raw);

  logic [31:0] elapsed;
  assign elapsed = now_q - rdata.last_run;

  always_comb begin
    state_d = state_q; live_d = live_q; idx_d = idx_q; rd_pend_d = 1'b0;
    fst_d = fst_q; fslot_d = fslot_q;
    we = 1'b0; waddr = idx_q[SlotW-1:0]; wdata = rdata; raddr = '0;
    valid_o = 1'b0; status_o = StDone; slot_o = '0; due_key_o = '0; last_o = 1'b0;
    case (state_q)
      SIdle: begin
        if (start_i) begin
          idx_d = '0;
          fst_d = StDone; fslot_d = '0;
          case (func_i)
            OpCreate: begin
              if (task_key_i == '0) begin
                fst_d = StNull; state_d = SEnd;
              end else if (live_q >= CntW'(TaskSlots)) begin
                fst_d = StFull; state_d = SEnd;
              end else begin
                state_d = SScan; rd_pend_d = live_q != '0;
              end
            end
            OpKill, OpSetPeriod: begin
              if (task_key_i == '0) begin
                fst_d = StNull; state_d = SEnd;
              end else begin
                state_d = SScan; rd_pend_d = live_q != '0;
              end
            end
            OpRun: begin
              state_d = SScan; rd_pend_d = live_q != '0;
            end
            OpKillAll: begin
              live_d = '0; state_d = SEnd;
            end
            default: state_d = SEnd;
          endcase
        end
      end
      SScan: begin
        if (!rd_pend_q) begin
          // walk done without a hit
          state_d = SEnd;
          case (func_q)
            OpCreate: begin
              we = 1'b1; waddr = live_q[SlotW-1:0];
              wdata.key = key_q; wdata.period = period_q; wdata.last_run = '0;
              live_d = live_q + 1'b1; fslot_d = live_q[SlotW-1:0];
            end
            OpKill, OpSetPeriod: fst_d = StAbsent;
            default: ;
          endcase
        end else begin
          logic hit;
          hit = rdata.key == key_q;
          if (func_q == OpRun) begin
            if (elapsed >= rdata.period) begin
              we = 1'b1; wdata.last_run = now_q;
              valid_o = 1'b1; status_o = StDue;
              slot_o = idx_q[SlotW-1:0]; due_key_o = rdata.key;
            end
            idx_d = idx_q + 1'b1;
            raddr = idx_d[SlotW-1:0];
            rd_pend_d = idx_d < live_q;
          end else if (hit) begin
            fslot_d = idx_q[SlotW-1:0];
            state_d = SEnd;
            if (func_q == OpCreate) begin
              fst_d = StPresent;
            end else if (func_q == OpSetPeriod) begin
              we = 1'b1; wdata.period = period_q; wdata.last_run = '0;
            end else begin
              // kill: shift later entries down
              if (idx_q + 1'b1 < live_q) begin
                state_d = SShift; idx_d = idx_q + 1'b1;
                raddr = idx_d[SlotW-1:0]; rd_pend_d = 1'b1;
              end else begin
                live_d = live_q - 1'b1;
              end
            end
          end else begin
            idx_d = idx_q + 1'b1;
            raddr = idx_d[SlotW-1:0];
            rd_pend_d = idx_d < live_q;
          end
        end
        if (state_d == SScan && rd_pend_d == 1'b0 && func_q == OpRun) state_d = SEnd;
      end
      SShift: begin
        // entry idx arrived: write it one slot lower
        we = 1'b1; waddr = idx_q[SlotW-1:0] - 1'b1;
        idx_d = idx_q + 1'b1;
        if (idx_d < live_q) begin
          raddr = idx_d[SlotW-1:0]; rd_pend_d = 1'b1;
        end else begin
          live_d = live_q - 1'b1; state_d = SEnd;
        end
      end
      SEnd: begin
        valid_o = 1'b1; status_o = fst_q; slot_o = fslot_q; last_o = 1'b1;
        state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
    if (state_q == SIdle && start_i) raddr = '0;
  end

  assign busy_o = state_q != SIdle;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; live_q <= '0; idx_q <= '0; rd_pend_q <= 1'b0;
    end else begin
      state_q <= state_d; live_q <= live_d; idx_q <= idx_d;
      rd_pend_q <= rd_pend_d;
    end
  end

  // command word and final result payload
  always_ff @(posedge clk_i) begin
    if (state_q == SIdle && start_i) begin
      func_q <= func_i; key_q <= task_key_i; period_q <= period_i; now_q <= now_tick_i;
    end
    fst_q <= fst_d; fslot_q <= fslot_d;
  end
endmodule

FILE: rtl/core/ptd_ram.sv
module ptd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

FILE: rtl/core/ptd_checker.sv
module ptd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        valid_o,
  input logic [2:0]  status_o,
  input logic        last_o
);
  import ptd_pkg::*;
`include "periodic_task_dispatch_table_assert.svh"

  `PTD_ASSERT_NXT(a_start_busy, start_i && !busy_o, busy_o, "accepted word not busy")
  `PTD_ASSERT_IMP(a_res_busy, valid_o, busy_o, "result while idle")
  `PTD_ASSERT_NXT(a_last_free, valid_o && last_o, !busy_o, "busy after last result")
  `PTD_ASSERT_IMP(a_due_notlast, valid_o && status_o == StDue, !last_o, "due marked last")
endmodule

bind periodic_task_dispatch_table ptd_checker u_ptd_checker (
  .clk_i, .rst_ni, .start_i, .busy_o, .valid_o, .status_o, .last_o
);
